// ===== design/rmf_pkg.sv =====
`default_nettype none
package rmf_pkg;

  // Window size and derived widths.
  localparam int WINDOW_LENGTH = 5;
  localparam int IDX_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CNT_W   = $clog2(WINDOW_LENGTH + 1);
  localparam int MED_IDX = (WINDOW_LENGTH - 1) / 2;
  localparam int DATA_W  = 8;

  typedef logic [DATA_W-1:0] sample_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } rmf_state_t;

endpackage
`default_nettype wire

// ===== design/running_median_filter.sv =====
`default_nettype none
// Running median filter over the last WINDOW_LENGTH detected samples.
//
// Input channel (in_valid/in_ready): one transaction carries in_sample and
// in_detected. A detected sample is shifted into the window, the oldest
// entry drops out, and the lower median of the window is returned. An
// undetected transaction leaves the window alone and returns 0.
// Output channel (out_valid/out_ready): one transaction per input, carrying
// out_median, in input order.
//
// Throughput: one item at a time. The median is found by a shared rank unit
// that tests one window entry per cycle against the whole window; a detected
// item is scanned from the oldest entry until one holds the median rank or
// the last entry is reached, while an undetected one skips the scan. A new
// item is taken only after the last result has moved to the output register.
// The output register holds a finished result while the receiver stalls;
// the next input is still taken and worked on, and its result waits until
// the output register frees up.
// Reset (rst_n low, synchronous) clears the window to zeros and empties the
// output register; the reset zeros take part in medians as ordinary values.
module running_median_filter (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rmf_pkg::sample_t in_sample,
  input  wire logic            in_detected,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rmf_pkg::sample_t     out_median
);
  import rmf_pkg::*;

  rmf_state_t        state_r, state_nxt;
  sample_t           win_r [WINDOW_LENGTH];
  logic [IDX_W-1:0]  cand_r;
  sample_t           res_r;
  logic              out_valid_r;
  sample_t           out_median_r;

  logic              in_fire;
  logic              load_out;
  logic              scan_hit;
  logic              scan_last;
  sample_t           cand;
  logic [CNT_W-1:0]  cnt_lt;
  logic [CNT_W-1:0]  cnt_le;

  assign in_fire   = in_valid && in_ready;
  assign scan_last = (cand_r == IDX_W'(WINDOW_LENGTH - 1));

  // Rank unit: count entries below and not above the current candidate.
  always_comb begin
    cand   = win_r[cand_r];
    cnt_lt = '0;
    cnt_le = '0;
    for (int j = 0; j < WINDOW_LENGTH; j++) begin
      cnt_lt = cnt_lt + CNT_W'(win_r[j] <  cand);
      cnt_le = cnt_le + CNT_W'(win_r[j] <= cand);
    end
    // Candidate sits at the median position of the sorted window.
    scan_hit = (cnt_lt <= CNT_W'(MED_IDX)) && (cnt_le > CNT_W'(MED_IDX));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_detected ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  ;
      S_DONE:  load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cand_r      <= '0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Shift a detected sample in; drop the oldest.
      if (in_fire) begin
        cand_r <= '0;
        if (in_detected) begin
          for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
            win_r[i] <= win_r[i+1];
          end
          win_r[WINDOW_LENGTH-1] <= in_sample;
        end
      end else if (state_r == S_SCAN && !scan_hit && !scan_last) begin
        cand_r <= cand_r + 1'b1;
      end

      // Hold a result until the receiver takes it.
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire && !in_detected) begin
      res_r <= '0;
    end else if (state_r == S_SCAN && (scan_hit || scan_last)) begin
      res_r <= cand;
    end
    if (load_out) begin
      out_median_r <= res_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

  // An accepted item always leaves the idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after an accepted transaction");

  // Loading the output register raises out_valid.
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid)
    else $error("out_valid low after result load");

  // An undetected item answers zero without scanning.
  a_undetected_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_detected) |=> (state_r == S_DONE && res_r == '0))
    else $error("undetected transaction did not go straight to a zero result");

  // A candidate that fails the rank test never lies beyond the last window entry.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !scan_hit) |-> (cand_r <= IDX_W'(WINDOW_LENGTH - 1)))
    else $error("candidate index ran past the window");

endmodule
`default_nettype wire

// ===== dv/running_median_filter_tb.sv =====
module running_median_filter_tb;
  import rmf_pkg::*;

  localparam int QUIET_LIMIT  = 5000; // cycles with no transaction on either side
  localparam int REPORT_CAP   = 10;
  localparam int TAIL_CYCLES  = 20;   // idle margin after the last checked result
  localparam int HOLD_CYCLES  = 300;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  sample_t in_sample;
  logic    in_detected;
  logic    out_valid;
  logic    out_ready;
  sample_t out_median;

  running_median_filter uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_detected (in_detected),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_median  (out_median)
  );

  always #1 clk = ~clk;

  // Traffic shaping knobs, set per test.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len       = 0;

  // Shadow of the filter window, oldest entry first, and the medians it predicts.
  sample_t sample_hist [WINDOW_LENGTH];
  sample_t expected_medians [$];
  sample_t want_median;

  int frames_in      = 0;
  int frames_seen    = 0;
  int detected_in    = 0;
  int medians_out    = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;
  int input_stalls   = 0;

  // Insertion sort of a copy of the shadow window; pick the lower median.
  function automatic sample_t window_lower_median();
    sample_t ordered [WINDOW_LENGTH];
    sample_t key;
    int      j;
    ordered = sample_hist;
    for (int i = 1; i < WINDOW_LENGTH; i++) begin
      key = ordered[i];
      j = i;
      while (j > 0 && ordered[j-1] > key) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = key;
    end
    return ordered[MED_IDX];
  endfunction

  // Bias toward the extremes and a narrow band so ties show up often.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return sample_t'($urandom_range(100, 103));
      default: return sample_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Predict on every accepted input transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (sample_hist[k]) sample_hist[k] = '0;
    end else if (in_valid && in_ready) begin
      frames_seen++;
      if (in_detected) begin
        for (int k = 0; k < WINDOW_LENGTH - 1; k++) sample_hist[k] = sample_hist[k+1];
        sample_hist[WINDOW_LENGTH-1] = in_sample;
        expected_medians.push_back(window_lower_median());
      end else begin
        // undetected: window untouched, answer is zero
        expected_medians.push_back('0);
      end
    end
  end

  // Check every accepted output transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      medians_out++;
      if (expected_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("ERROR: unexpected median %0d with nothing pending", out_median);
      end else begin
        want_median = expected_medians.pop_front();
        if (out_median !== want_median) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("ERROR: median %0d, expected %0d (result %0d)",
                     out_median, want_median, medians_out);
        end
      end
    end
  end

  // Count input stalls and cycles without any transaction.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_ready) input_stalls++;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  initial begin
    int held;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        held = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (held - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one frame and hold it until the filter takes it; valid stays up on return.
  task automatic offer_frame(input sample_t s, input logic det);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_sample   <= s;
    in_detected <= det;
    frames_in++;
    if (det) detected_in++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Right after reset: zeros in the window, extremes, ties, undetected frames.
  task automatic test_startup_and_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    offer_frame(8'd7,   1'b1);
    offer_frame(8'd255, 1'b0);
    offer_frame(8'd255, 1'b1);
    offer_frame(8'd255, 1'b1);
    offer_frame(8'd0,   1'b0);
    offer_frame(8'd255, 1'b1);
    offer_frame(8'd255, 1'b1);
    offer_frame(8'd0,   1'b1);
    offer_frame(8'd170, 1'b0);
    offer_frame(8'd85,  1'b1);
    repeat (5) offer_frame(8'd42, 1'b1);
    offer_frame(8'd1,   1'b1);
    offer_frame(8'd254, 1'b1);
    offer_frame(8'd128, 1'b1);
    offer_frame(8'd127, 1'b1);
    offer_frame(8'd0,   1'b1);
    offer_frame(8'd0,   1'b0);
    offer_frame(8'd255, 1'b1);
  endtask

  // Mostly detected frames with random content, some undetected noise.
  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) offer_frame(pick_sample(), $urandom_range(0, 99) < 80);
  endtask

  // Block the receiver for a long stretch while frames keep coming.
  task automatic test_output_backpressure();
    int stalls_before;
    stalls_before  = input_stalls;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = HOLD_CYCLES;
    repeat (30) offer_frame(pick_sample(), $urandom_range(0, 99) < 90);
    if (input_stalls - stalls_before < HOLD_CYCLES / 2)
      $display("NOTE: input stalled only %0d cycles during hold-off",
               input_stalls - stalls_before);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_sample   = '0;
    in_detected = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_startup_and_extremes();
    test_random_traffic(180, 0, 0);
    test_random_traffic(180, 48, 0);
    test_output_backpressure();
    test_random_traffic(180, 0, 48);
    test_random_traffic(180, 27, 27);

    in_valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d frames (%0d detected), checked %0d medians, %0d input stall cycles",
             frames_in, detected_in, medians_out, input_stalls);
    $display("Phases: reset zeros, extremes, ties, idle/stall mixes, long output hold-off");
    if (mismatches == 0 && expected_medians.size() == 0 && frames_seen == frames_in) begin
      $display("Regression PASS");
    end else begin
      $display("ERROR: %0d mismatches, %0d medians outstanding",
               mismatches, expected_medians.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== running_median_filter.f =====
design/rmf_pkg.sv
design/running_median_filter.sv
dv/running_median_filter_tb.sv
